// ===== sv/prf_pkg.sv =====
// Shared types and constants for the per-feature regression fit/predict core.
// Used by prf_lane, the top level and the checker.
`default_nettype none

package prf_pkg;

   // Word field widths.
   localparam int CNT_W   = 11;
   localparam int X_W     = 16;
   localparam int PRICE_W = 24;

   // Running-sum widths, sized for at most 1024 accumulated words.
   localparam int SX_W  = X_W + CNT_W;
   localparam int SQ_W  = 2 * X_W;
   localparam int XP_W  = X_W + PRICE_W;
   localparam int SXX_W = SQ_W + CNT_W;
   localparam int SXY_W = XP_W + CNT_W;
   localparam int PS_W  = PRICE_W + CNT_W;

   // Fitting widths.
   localparam int PROD_W  = CNT_W + SXY_W;
   localparam int DEN_W   = CNT_W + SXX_W;
   localparam int FRAC_W  = 16;
   localparam int SDVD_W  = PROD_W + FRAC_W;
   localparam int SLOPE_W = 64;
   localparam int ACC_W   = 100;
   localparam int OPND_W  = 32;
   localparam int EST_W   = 32;

   localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic [EST_W-1:0]   EST_MAX   = {1'b0, {(EST_W-1){1'b1}}};
   localparam logic [EST_W-1:0]   EST_MIN   = {1'b1, {(EST_W-1){1'b0}}};

   // Action codes.
   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_EST = 2'd1;
   localparam logic [1:0] ACT_CLR = 2'd2;

   // Result kinds.
   localparam logic KIND_EST = 1'b0;
   localparam logic KIND_FIT = 1'b1;

   // Sequencer commands broadcast to every lane.
   typedef struct packed {
      logic load;     // latch the feature and its products
      logic add;      // accumulate into the running sums
      logic clear;    // zero sums and slope
      logic fprd;     // form the fit products
      logic fden;     // form numerator magnitude and denominator
      logic dstart;   // start the slope divider
      logic mul;      // slope times operand, partial products
      logic sel_sum;  // operand is the feature sum, else the feature
      logic cmb;      // combine partial products
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== sv/prf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module prf_div #(
   parameter int DVD_W = 78,
   parameter int DVS_W = 54
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic             ge;

   // One shift-and-subtract step.
   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/prf_lane.sv =====
// One feature lane: running sums, slope fit with its own divider, and the
// slope-times-operand product. Depends on prf_pkg and prf_div.
`default_nettype none

module prf_lane import prf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lane_ctl_type       ctl,
   input  wire logic [X_W-1:0]     feat,
   input  wire logic [PRICE_W-1:0] price,
   input  wire logic [CNT_W-1:0]   count,
   input  wire logic [PS_W-1:0]    psum,
   output logic                    div_done,
   output logic signed [ACC_W-1:0] prod
);

   logic [X_W-1:0]    x_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [XP_W-1:0]   xp_ff;
   logic [SX_W-1:0]   sx_ff;
   logic [SXX_W-1:0]  sxx_ff;
   logic [SXY_W-1:0]  sxy_ff;
   logic [PROD_W-1:0] a_ff, b_ff, mag_ff;
   logic [DEN_W-1:0]  nsxx_ff, sxsx_ff, den_ff;
   logic              neg_ff;
   logic [SLOPE_W-1:0] slope_ff, slope_in;
   logic [63:0]        plo_ff;
   logic signed [64:0] phi_ff, phi_in;
   logic [OPND_W-1:0]  opnd;
   logic signed [ACC_W-1:0] prod_ff;
   logic [SDVD_W-1:0]  quo;
   logic [SLOPE_W-1:0] qsat;

   // Input stage: latch the feature and its square and price product.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff  <= feat;
         sq_ff <= SQ_W'(feat) * SQ_W'(feat);
         xp_ff <= XP_W'(feat) * XP_W'(price);
      end
   end

   // Running sums.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         sx_ff  <= '0;
         sxx_ff <= '0;
         sxy_ff <= '0;
      end else if (ctl.add) begin
         sx_ff  <= sx_ff + SX_W'(x_ff);
         sxx_ff <= sxx_ff + SXX_W'(sq_ff);
         sxy_ff <= sxy_ff + SXY_W'(xp_ff);
      end
   end

   // Fit products, then numerator magnitude and denominator.
   always_ff @(posedge clock) begin
      if (ctl.fprd) begin
         a_ff    <= PROD_W'(count) * PROD_W'(sxy_ff);
         b_ff    <= PROD_W'(sx_ff) * PROD_W'(psum);
         nsxx_ff <= DEN_W'(count) * DEN_W'(sxx_ff);
         sxsx_ff <= DEN_W'(sx_ff) * DEN_W'(sx_ff);
      end
      if (ctl.fden) begin
         neg_ff <= a_ff < b_ff;
         mag_ff <= (a_ff < b_ff) ? b_ff - a_ff : a_ff - b_ff;
         den_ff <= nsxx_ff - sxsx_ff;
      end
   end

   prf_div #(
      .DVD_W (SDVD_W),
      .DVS_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.dstart),
      .dividend ({mag_ff, {FRAC_W{1'b0}}}),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // Saturate the Q16 quotient and apply the sign; a zero denominator gives 0.
   assign qsat = (|quo[SDVD_W-1:SLOPE_W-1]) ? SLOPE_MAX : quo[SLOPE_W-1:0];

   always_comb begin
      slope_in = slope_ff;
      if (div_done) begin
         if (den_ff == '0) begin
            slope_in = '0;
         end else begin
            slope_in = neg_ff ? -qsat : qsat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         slope_ff <= '0;
      end else begin
         slope_ff <= slope_in;
      end
   end

   // Signed slope times unsigned operand in two 32-bit partial products.
   assign opnd   = ctl.sel_sum ? OPND_W'(sx_ff) : OPND_W'(x_ff);
   assign phi_in = $signed({{33{slope_ff[63]}}, slope_ff[63:32]}) * $signed({33'b0, opnd});

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         plo_ff <= 64'(slope_ff[31:0]) * 64'(opnd);
         phi_ff <= phi_in;
      end
      if (ctl.cmb) begin
         prod_ff <= $signed({{(ACC_W-65){phi_ff[64]}}, phi_ff} <<< 32)
                  + $signed({{(ACC_W-64){1'b0}}, plo_ff});
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== sv/per_feature_regression_fit_predict_core.sv =====
// Per-feature least-squares fit and price estimate. Depends on prf_pkg,
// prf_lane and prf_div.
// A training word passes through the add state. An estimate is set by the
// serial merge over the lanes. A fitting word is set by the bit-serial
// slope and intercept dividers.
// One word at a time; a finished result waits in the output register.
// Synchronous active-high reset clears all sums, slopes, intercept and count.
`default_nettype none

module per_feature_regression_fit_predict_core import prf_pkg::*; #(
   parameter int MAX_SAMPLES  = 1024,
   parameter int NUM_FEATURES = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [15:0]        req_area_sq_ft,
   input  wire logic [3:0]         req_bedroom_count,
   input  wire logic [3:0]         req_bathroom_count,
   input  wire logic [7:0]         req_property_age,
   input  wire logic [3:0]         req_location_rank,
   input  wire logic [PRICE_W-1:0] req_sale_price,
   input  wire logic               req_last_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_result_kind,
   output logic signed [EST_W-1:0] rsp_estimate,
   output logic [CNT_W-1:0]        rsp_samples_used
);

   localparam int LIX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ADD   = 4'd1;
   localparam logic [3:0] S_FPRD  = 4'd2;
   localparam logic [3:0] S_FDEN  = 4'd3;
   localparam logic [3:0] S_FDIV0 = 4'd4;
   localparam logic [3:0] S_FDIV  = 4'd5;
   localparam logic [3:0] S_FMUL  = 4'd6;
   localparam logic [3:0] S_FCMB  = 4'd7;
   localparam logic [3:0] S_FMRG  = 4'd8;
   localparam logic [3:0] S_IDIV0 = 4'd9;
   localparam logic [3:0] S_IDIV  = 4'd10;
   localparam logic [3:0] S_EMUL  = 4'd11;
   localparam logic [3:0] S_ECMB  = 4'd12;
   localparam logic [3:0] S_EMRG  = 4'd13;
   localparam logic [3:0] S_EOUT  = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   logic [3:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [PS_W-1:0]          psum_ff, psum_in;
   logic [SLOPE_W-1:0]       icpt_ff, icpt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [LIX_W-1:0]         lix_ff, lix_in;
   logic [PRICE_W-1:0]       price_ff;
   logic                     last_ff;
   logic                     ineg_ff, ineg_in;
   logic                     res_kind_ff, res_kind_in;
   logic [EST_W-1:0]         res_est_ff, res_est_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff;
   logic [EST_W-1:0]         rsp_est_ff;
   logic [CNT_W-1:0]         rsp_cnt_ff;
   logic                     rsp_load;
   logic                     accept;
   logic                     full;
   lane_ctl_type             ctl;
   logic [NUM_FEATURES-1:0]  lane_done;
   logic signed [ACC_W-1:0]  lane_prod [NUM_FEATURES];
   logic                     idiv_start;
   logic                     idiv_done;
   logic [ACC_W-1:0]         acc_mag;
   logic [ACC_W-1:0]         iquo;
   logic signed [ACC_W:0]    ires;
   logic [SLOPE_W-1:0]       isat;
   logic signed [ACC_W-1:0]  acc_sh;
   logic [EST_W-1:0]         est_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (cnt_ff == CNT_W'(MAX_SAMPLES));

   // Feature lanes; lanes past the fifth see a zero feature.
   for (genvar j = 0; j < NUM_FEATURES; j++) begin : g_lane
      logic [X_W-1:0] feat;
      if (j == 0) begin : g_f0
         assign feat = req_area_sq_ft;
      end else if (j == 1) begin : g_f1
         assign feat = X_W'(req_bedroom_count);
      end else if (j == 2) begin : g_f2
         assign feat = X_W'(req_bathroom_count);
      end else if (j == 3) begin : g_f3
         assign feat = X_W'(req_property_age);
      end else if (j == 4) begin : g_f4
         assign feat = X_W'(req_location_rank);
      end else begin : g_fz
         assign feat = '0;
      end

      prf_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .feat     (feat),
         .price    (req_sale_price),
         .count    (cnt_ff),
         .psum     (psum_ff),
         .div_done (lane_done[j]),
         .prod     (lane_prod[j])
      );
   end

   // Intercept divider: magnitude of the accumulated numerator over n.
   assign acc_mag    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign idiv_start = (state_ff == S_IDIV0);

   prf_div #(
      .DVD_W (ACC_W),
      .DVS_W (CNT_W)
   ) u_idiv (
      .clock    (clock),
      .reset    (reset),
      .start    (idiv_start),
      .dividend (acc_mag),
      .divisor  (cnt_ff),
      .done     (idiv_done),
      .quotient (iquo)
   );

   assign ires = ineg_ff ? -$signed({1'b0, iquo}) : $signed({1'b0, iquo});
   assign isat = ((&ires[ACC_W:SLOPE_W-1]) || !(|ires[ACC_W:SLOPE_W-1]))
                 ? ires[SLOPE_W-1:0] : (ires[ACC_W] ? SLOPE_MIN : SLOPE_MAX);

   // Q16 to Q0 with floor, then saturate to 32 bits.
   assign acc_sh  = acc_ff >>> FRAC_W;
   assign est_sat = ((&acc_sh[ACC_W-1:EST_W-1]) || !(|acc_sh[ACC_W-1:EST_W-1]))
                    ? acc_sh[EST_W-1:0] : (acc_sh[ACC_W-1] ? EST_MIN : EST_MAX);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      psum_in     = psum_ff;
      icpt_in     = icpt_ff;
      acc_in      = acc_ff;
      lix_in      = lix_ff;
      ineg_in     = ineg_ff;
      res_kind_in = res_kind_ff;
      res_est_in  = res_est_ff;
      rsp_load    = 1'b0;
      ctl         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_ADD: begin
                     ctl.load = 1'b1;
                     state_in = S_ADD;
                  end
                  ACT_EST: begin
                     ctl.load = 1'b1;
                     state_in = S_EMUL;
                  end
                  ACT_CLR: begin
                     ctl.clear = 1'b1;
                     cnt_in    = '0;
                     psum_in   = '0;
                     icpt_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD: begin
            if (!full) begin
               ctl.add = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               psum_in = psum_ff + PS_W'(price_ff);
            end
            state_in = last_ff ? S_FPRD : S_IDLE;
         end
         S_FPRD: begin
            ctl.fprd = 1'b1;
            state_in = S_FDEN;
         end
         S_FDEN: begin
            ctl.fden = 1'b1;
            state_in = S_FDIV0;
         end
         S_FDIV0: begin
            ctl.dstart = 1'b1;
            state_in   = S_FDIV;
         end
         S_FDIV: begin
            if (&lane_done) begin
               state_in = S_FMUL;
            end
         end
         S_FMUL: begin
            ctl.mul     = 1'b1;
            ctl.sel_sum = 1'b1;
            acc_in      = $signed(ACC_W'({psum_ff, {FRAC_W{1'b0}}}));
            state_in    = S_FCMB;
         end
         S_FCMB: begin
            ctl.cmb  = 1'b1;
            lix_in   = '0;
            state_in = S_FMRG;
         end
         S_FMRG: begin
            acc_in = acc_ff - lane_prod[lix_ff];
            lix_in = lix_ff + 1'b1;
            if (lix_ff == LIX_W'(NUM_FEATURES - 1)) begin
               state_in = S_IDIV0;
            end
         end
         S_IDIV0: begin
            ineg_in  = acc_ff[ACC_W-1];
            state_in = S_IDIV;
         end
         S_IDIV: begin
            if (idiv_done) begin
               icpt_in     = (cnt_ff == '0) ? '0 : isat;
               res_kind_in = KIND_FIT;
               res_est_in  = '0;
               state_in    = S_OUT;
            end
         end
         S_EMUL: begin
            ctl.mul  = 1'b1;
            acc_in   = $signed({{(ACC_W-SLOPE_W){icpt_ff[SLOPE_W-1]}}, icpt_ff});
            state_in = S_ECMB;
         end
         S_ECMB: begin
            ctl.cmb  = 1'b1;
            lix_in   = '0;
            state_in = S_EMRG;
         end
         S_EMRG: begin
            acc_in = acc_ff + lane_prod[lix_ff];
            lix_in = lix_ff + 1'b1;
            if (lix_ff == LIX_W'(NUM_FEATURES - 1)) begin
               state_in = S_EOUT;
            end
         end
         S_EOUT: begin
            res_kind_in = KIND_EST;
            res_est_in  = est_sat;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         psum_ff      <= '0;
         icpt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         psum_ff      <= psum_in;
         icpt_ff      <= icpt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      lix_ff      <= lix_in;
      ineg_ff     <= ineg_in;
      res_kind_ff <= res_kind_in;
      res_est_ff  <= res_est_in;
      if (accept) begin
         price_ff <= req_sale_price;
         last_ff  <= req_last_sample;
      end
      if (rsp_load) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_est_ff  <= res_est_ff;
         rsp_cnt_ff  <= cnt_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_estimate     = $signed(rsp_est_ff);
   assign rsp_samples_used = rsp_cnt_ff;

endmodule

`default_nettype wire

// ===== sv/prf_checker.sv =====
// Port-level checks for the regression core, bound to the top level.
// Depends on prf_pkg.
`default_nettype none

module prf_checker import prf_pkg::*; #(
   parameter int MAX_SAMPLES = 1024
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_result_kind,
   input wire logic signed [EST_W-1:0] rsp_estimate,
   input wire logic [CNT_W-1:0]        rsp_samples_used
);

   // A waiting result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its estimate.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_estimate))
      else $error("result estimate changed while stalled");

   // A fitting-complete word carries a zero estimate.
   a_fit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_FIT |-> rsp_estimate == '0)
      else $error("fitting-complete word with nonzero estimate");

   // The sample count never passes the store size.
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_samples_used <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above limit");

   // Reset leaves no result pending.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind per_feature_regression_fit_predict_core prf_checker #(
   .MAX_SAMPLES (MAX_SAMPLES)
) u_prf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_estimate     (rsp_estimate),
   .rsp_samples_used (rsp_samples_used)
);

`default_nettype wire
